// ===== rtl/core/vsvs_pkg.sv =====
// ---------------------------------------------------------------------------
// vsvs_pkg
// Shared word types and fixed constants of the velocity smoother.
// ---------------------------------------------------------------------------
package vsvs_pkg;

  localparam int unsigned VelW   = 24;
  localparam int unsigned StampW = 32;
  localparam int unsigned TauW   = 24;
  localparam int unsigned SeqW   = 32;
  localparam int unsigned AlphaW = 17;       // Q0.16 plus the 1.0 code
  localparam int unsigned RatioSpanLog = 3;  // dt/tau span of the table is 8
  localparam int unsigned TaylorTerms = 20;
  localparam logic [AlphaW-1:0] ALPHA_ONE = 17'h10000;
  localparam logic [VelW-1:0]   VEL_BIAS  = 24'h800000;

  // register indexes
  localparam logic REG_FILTER_ENABLE = 1'b0;
  localparam logic REG_TAU_US        = 1'b1;

  typedef struct packed {
    logic                     target_slot;
    logic                     pos_valid;
    logic signed [VelW-1:0]   raw_vel_x;
    logic signed [VelW-1:0]   raw_vel_y;
    logic [StampW-1:0]        stamp_us;
  } in_word_t;

  typedef struct packed {
    logic                     out_slot;
    logic signed [VelW-1:0]   smooth_vel_x;
    logic signed [VelW-1:0]   smooth_vel_y;
    logic [SeqW-1:0]          sample_seq;
  } out_word_t;

endpackage

// ===== rtl/core/vsvs_blend.sv =====
// ---------------------------------------------------------------------------
// vsvs_blend
// Bit-serial blend of two velocity pairs: alpha*raw + (1-alpha)*prev.
// ---------------------------------------------------------------------------
module vsvs_blend
  import vsvs_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [AlphaW-1:0]     alpha_i,
  input  logic [VelW-1:0]       raw_x_i,
  input  logic [VelW-1:0]       raw_y_i,
  input  logic [VelW-1:0]       prev_x_i,
  input  logic [VelW-1:0]       prev_y_i,
  output logic                  done_o,
  output logic [VelW-1:0]       vel_x_o,
  output logic [VelW-1:0]       vel_y_o
);

  localparam int unsigned AccW = VelW + AlphaW;
  localparam int unsigned CntW = $clog2(AlphaW + 1);

  logic              busy_q, busy_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [AlphaW-1:0] a_q, a_d, b_q, b_d;
  logic [VelW-1:0]   rx_q, ry_q, px_q, py_q;
  logic [AccW-1:0]   accx_q, accx_d, accy_q, accy_d;
  logic [AccW-1:0]   sx, sy;

  // one alpha bit per cycle, MSB first, both axes side by side;
  // done is flagged for a single cycle once the full sum is in the accumulators
  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    a_d    = a_q;
    b_d    = b_q;
    accx_d = accx_q;
    accy_d = accy_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      a_d    = alpha_i;
      b_d    = ALPHA_ONE - alpha_i;
      accx_d = '0;
      accy_d = '0;
    end else if (busy_q) begin
      if (cnt_q == CntW'(AlphaW)) begin
        busy_d = 1'b0;
      end else begin
        accx_d = {accx_q[AccW-2:0], 1'b0}
               + (a_q[AlphaW-1] ? AccW'(rx_q) : '0)
               + (b_q[AlphaW-1] ? AccW'(px_q) : '0);
        accy_d = {accy_q[AccW-2:0], 1'b0}
               + (a_q[AlphaW-1] ? AccW'(ry_q) : '0)
               + (b_q[AlphaW-1] ? AccW'(py_q) : '0);
        a_d    = {a_q[AlphaW-2:0], 1'b0};
        b_d    = {b_q[AlphaW-2:0], 1'b0};
        cnt_d  = cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q    <= a_d;
    b_q    <= b_d;
    accx_q <= accx_d;
    accy_q <= accy_d;
    if (start_i) begin
      // offset binary so the sum stays unsigned
      rx_q <= raw_x_i ^ VEL_BIAS;
      ry_q <= raw_y_i ^ VEL_BIAS;
      px_q <= prev_x_i ^ VEL_BIAS;
      py_q <= prev_y_i ^ VEL_BIAS;
    end
  end

  // round, drop the fraction, back to two's complement
  assign sx      = accx_q + AccW'(32768);
  assign sy      = accy_q + AccW'(32768);
  assign vel_x_o = sx[VelW+15:16] ^ VEL_BIAS;
  assign vel_y_o = sy[VelW+15:16] ^ VEL_BIAS;
  assign done_o  = busy_q && (cnt_q == CntW'(AlphaW));

`ifndef SYNTHESIS
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && !done_o |=> busy_q) else $error("blend stopped early");
  a_done_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("blend done repeated");
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q || done_o) else $error("blend restarted while busy");
`endif

endmodule

// ===== rtl/core/variable_step_velocity_smoother_unit.sv =====
// ---------------------------------------------------------------------------
// variable_step_velocity_smoother_unit
// Variable-timestep low-pass filter of 2-D velocity for tracked objects.
// ---------------------------------------------------------------------------
//  channel | signals                              | word
//  in      | in_valid_i / in_ready_o / in_word_i  | in_word_t
//  out     | out_valid_o / out_ready_i/out_word_o | out_word_t
//  cfg     | psel penable pwrite paddr pwdata ... | 32-bit registers
//
// A word filtered through the divider passes the check, the serial dt/tau
// divider, the table read, the bit-serial blend and the output load. With
// dt >= 8*tau the divider and table read are skipped; unfiltered words go from
// the check straight to the output load. The next word is taken in the idle
// state that follows the output load.
// One word is in flight; the next is taken while a result waits on out.
// Reset clears all per-object state and the registers; no clearing pass.
// ---------------------------------------------------------------------------
module variable_step_velocity_smoother_unit
  import vsvs_pkg::*;
#(
  parameter int unsigned NUM_TARGETS       = 2,
  parameter int unsigned ALPHA_TABLE_DEPTH = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_word_t    in_word_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_word_t   out_word_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned TgtW = (NUM_TARGETS > 1) ? $clog2(NUM_TARGETS) : 1;
  localparam int unsigned QW   = $clog2(ALPHA_TABLE_DEPTH);
  localparam int unsigned DW   = StampW + QW;
  localparam int unsigned CntW = $clog2(QW + 1);
  localparam logic [63:0] StepH = (64'd1 << (32 + RatioSpanLog)) / ALPHA_TABLE_DEPTH;

  typedef logic [ALPHA_TABLE_DEPTH-1:0][AlphaW-1:0] alpha_tab_t;

  // alpha = 1 - exp(-i*h) in Q0.16, built in Q0.32
  function automatic alpha_tab_t build_tab(input logic [63:0] h);
    alpha_tab_t  tab;
    logic [63:0] term, r, e;
    term = 64'd1 << 32;
    r    = 64'd1 << 32;
    e    = 64'd1 << 32;
    for (int n = 1; n <= TaylorTerms; n++) begin
      term = ((term * h) >> 32) / 64'(n);
      if (n % 2 == 1) r = r - term;
      else r = r + term;
    end
    tab[0] = '0;
    for (int i = 1; i < ALPHA_TABLE_DEPTH; i++) begin
      e      = (e * r + (64'd1 << 31)) >> 32;
      tab[i] = AlphaW'(((64'd1 << 32) - e + 64'd32768) >> 16);
    end
    return tab;
  endfunction

  localparam alpha_tab_t ALPHA_TAB = build_tab(StepH);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CHK  = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_LOOK = 3'd3;
  localparam logic [2:0] S_MUL  = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  // configuration registers
  logic          fen_q;
  logic [TauW-1:0] tau_q;
  logic          cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fen_q <= 1'b0;
      tau_q <= '0;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_FILTER_ENABLE: fen_q <= pwdata[0];
        REG_TAU_US:        tau_q <= pwdata[TauW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_FILTER_ENABLE: prdata = {31'd0, fen_q};
      REG_TAU_US:        prdata = {8'd0, tau_q};
      default:           prdata = '0;
    endcase
  end

  // per-object state
  logic [VelW-1:0]   pvx_q [NUM_TARGETS];
  logic [VelW-1:0]   pvy_q [NUM_TARGETS];
  logic [StampW-1:0] pst_q [NUM_TARGETS];
  logic              seen_q [NUM_TARGETS];
  logic [SeqW-1:0]   cnt_seq_q [NUM_TARGETS];

  // word in work
  logic [2:0]        state_q, state_d;
  in_word_t          w_q;
  logic [TgtW-1:0]   slot_q;
  logic              filt_q;
  logic [VelW-1:0]   vx_q, vy_q;
  logic [AlphaW-1:0] alpha_q;
  logic [DW-1:0]     rem_q, dsh_q;
  logic [QW-1:0]     quot_q;
  logic [CntW-1:0]   step_q;
  logic [StampW-1:0] dt;
  logic              in_acc, out_load, go_filt, far;
  logic              bl_start, bl_done;
  logic [VelW-1:0]   bl_x, bl_y;
  logic              out_valid_q;
  out_word_t         out_q;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_load   = (state_q == S_DONE) && (!out_valid_q || out_ready_i);
  assign dt         = w_q.stamp_us - pst_q[slot_q];
  assign go_filt    = w_q.pos_valid && fen_q && seen_q[slot_q]
                    && (w_q.stamp_us > pst_q[slot_q]) && (tau_q != '0);
  assign far        = dt >= StampW'({tau_q, 3'b000});
  assign bl_start   = (state_q == S_LOOK) || ((state_q == S_CHK) && go_filt && far);

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (in_acc) state_d = S_CHK;
      S_CHK: begin
        if (!go_filt) state_d = S_DONE;
        else if (far) state_d = S_MUL;
        else state_d = S_DIV;
      end
      S_DIV:  if (step_q == CntW'(QW - 1)) state_d = S_LOOK;
      S_LOOK: state_d = S_MUL;
      S_MUL:  if (bl_done) state_d = S_DONE;
      S_DONE: if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      step_q      <= '0;
      for (int i = 0; i < NUM_TARGETS; i++) begin
        pvx_q[i]     <= '0;
        pvy_q[i]     <= '0;
        pst_q[i]     <= '0;
        seen_q[i]    <= 1'b0;
        cnt_seq_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (out_load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      step_q <= (state_q == S_DIV) ? step_q + 1'b1 : '0;
      // commit per-object state with the result
      if (out_load) begin
        cnt_seq_q[slot_q] <= cnt_seq_q[slot_q] + 1'b1;
        if (w_q.pos_valid && fen_q) begin
          pvx_q[slot_q]  <= vx_q;
          pvy_q[slot_q]  <= vy_q;
          pst_q[slot_q]  <= w_q.stamp_us;
          seen_q[slot_q] <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      w_q    <= in_word_i;
      slot_q <= (NUM_TARGETS > 1) ? TgtW'(in_word_i.target_slot) : '0;
    end
    case (state_q)
      S_CHK: begin
        filt_q <= go_filt;
        vx_q   <= w_q.pos_valid ? w_q.raw_vel_x : '0;
        vy_q   <= w_q.pos_valid ? w_q.raw_vel_y : '0;
        alpha_q <= ALPHA_ONE;
        rem_q  <= DW'(dt) * DW'(ALPHA_TABLE_DEPTH);
        dsh_q  <= DW'({tau_q, 3'b000}) << (QW - 1);
        quot_q <= '0;
      end
      S_DIV: begin
        // one quotient bit per cycle
        if (rem_q >= dsh_q) begin
          rem_q  <= rem_q - dsh_q;
          quot_q <= {quot_q[QW-2:0], 1'b1};
        end else begin
          quot_q <= {quot_q[QW-2:0], 1'b0};
        end
        dsh_q <= dsh_q >> 1;
      end
      S_LOOK: alpha_q <= ALPHA_TAB[quot_q];
      S_MUL: if (bl_done) begin
        vx_q <= bl_x;
        vy_q <= bl_y;
      end
      default: ;
    endcase
    if (out_load) begin
      out_q.out_slot     <= 1'(slot_q);
      out_q.smooth_vel_x <= vx_q;
      out_q.smooth_vel_y <= vy_q;
      out_q.sample_seq   <= cnt_seq_q[slot_q] + 1'b1;
    end
  end

  vsvs_blend u_blend (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (bl_start),
    .alpha_i  ((state_q == S_LOOK) ? ALPHA_TAB[quot_q] : ALPHA_ONE),
    .raw_x_i  (w_q.raw_vel_x),
    .raw_y_i  (w_q.raw_vel_y),
    .prev_x_i (pvx_q[slot_q]),
    .prev_y_i (pvy_q[slot_q]),
    .done_o   (bl_done),
    .vel_x_o  (bl_x),
    .vel_y_o  (bl_y)
  );

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

`ifndef SYNTHESIS
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ready_o) else $error("second word taken in flight");
  a_mul_filtered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_MUL |-> filt_q && alpha_q <= ALPHA_ONE) else $error("blend on raw word");
  a_seq_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> out_q.sample_seq == cnt_seq_q[slot_q]) else $error("counter mismatch");
`endif

endmodule
